FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the path ordering RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gnpo_pkg.sv
// Shared types and constants for the greedy path ordering core.
`timescale 1ns / 1ps
`default_nettype none

package gnpo_pkg;

  localparam int PATH_NUM_W = 6;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_READ,
    ST_START,
    ST_DIST,
    ST_CMP1,
    ST_CMP2,
    ST_SWAP1,
    ST_SWAP2,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dist_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/gnpo_ifs.sv
// Channel interfaces for path input, ordered results and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface gnpo_path_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] final_x;
  logic signed [COORD_BITS-1:0] final_y;
  logic                         last_path;

  modport source (output valid, first_x, first_y, final_x, final_y, last_path,
                  input ready);
  modport sink   (input valid, first_x, first_y, final_x, final_y, last_path,
                  output ready);
endinterface

interface gnpo_result_if;
  logic                            valid;
  logic                            ready;
  logic [gnpo_pkg::PATH_NUM_W-1:0] path_number;
  logic                            reversed;
  logic                            overflowed;
  logic                            last_of_order;

  modport source (output valid, path_number, reversed, overflowed, last_of_order,
                  input ready);
  modport sink   (input valid, path_number, reversed, overflowed, last_of_order,
                  output ready);
endinterface

interface gnpo_cfg_if #(parameter int DATA_W = 32);
  logic                           valid;
  logic                           ready;
  logic [gnpo_pkg::CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]              data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/greedy_nearest_path_order_core.sv
// Greedy nearest-neighbor path ordering core: top level with sequencer and path store.
// Paths are loaded one beat per cycle into a MAX_PATHS-deep store; the beat carrying
// last_path starts the ordering, during which no path is accepted. For every candidate
// the shared distance unit squares the four coordinate differences as twelve half-width
// partial products on one multiplier. Ordering holds in the emit state while the previous
// result still waits on out_ch.ready. Results leave through an output register, so the
// next slot is searched while the previous result waits.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module greedy_nearest_path_order_core #(
  parameter int MAX_PATHS  = 64,
  parameter int COORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  gnpo_path_if.sink     in_ch,
  gnpo_result_if.source out_ch,
  gnpo_cfg_if.sink      cfg_ch
);

  localparam int C      = COORD_BITS;
  localparam int IDX_W  = $clog2(MAX_PATHS);
  localparam int CNT_W  = $clog2(MAX_PATHS + 1);
  localparam int ENT_W  = 4 * COORD_BITS + IDX_W;
  localparam int DIST_W = 2 * COORD_BITS + 1;
  localparam logic [C-1:0] SIGN_FLIP = {1'b1, {(C-1){1'b0}}};

  gnpo_pkg::state_t state_r;
  gnpo_pkg::state_t state_nxt;

  logic [CNT_W-1:0]  cnt_r;
  logic              drop_r;
  logic [IDX_W-1:0]  slot_r;
  logic [IDX_W-1:0]  scan_r;
  logic [IDX_W-1:0]  pick_r;
  logic              pick_rev_r;
  logic              first_r;
  logic [DIST_W-1:0] best_r;
  logic [DIST_W-1:0] d_r;
  logic              rev_r;
  logic [C-1:0]      cur_x_r;
  logic [C-1:0]      cur_y_r;
  logic [C-1:0]      start_x_r;
  logic [C-1:0]      start_y_r;
  logic [ENT_W-1:0]  slot_ent_r;
  logic [ENT_W-1:0]  pick_ent_r;

  logic                            out_valid_r;
  logic [gnpo_pkg::PATH_NUM_W-1:0] out_num_r;
  logic                            out_rev_r;
  logic                            out_ovf_r;
  logic                            out_last_r;

  logic             in_fire;
  logic             has_room;
  logic             last_scan;
  logic             last_slot;
  logic             emit_go;
  logic             take_pick;
  logic             dist_start;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [ENT_W-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [ENT_W-1:0] mem_rd_data;

  logic [C-1:0]     ent_hx;
  logic [C-1:0]     ent_hy;
  logic [C-1:0]     ent_tx;
  logic [C-1:0]     ent_ty;
  logic [C-1:0]     pick_hx;
  logic [C-1:0]     pick_hy;
  logic [C-1:0]     pick_tx;
  logic [C-1:0]     pick_ty;
  logic [IDX_W-1:0] pick_num;

  logic [DIST_W-1:0]      dist_head;
  logic [DIST_W-1:0]      dist_tail;
  gnpo_pkg::dist_status_t dist_st;
  logic                   head_closer;

  // Entry layout, high to low: head x, head y, tail x, tail y, load number.
  // Coordinates are kept in offset binary so unsigned compares order them.
  assign ent_hx   = mem_rd_data[ENT_W-1 -: C];
  assign ent_hy   = mem_rd_data[ENT_W-1-C -: C];
  assign ent_tx   = mem_rd_data[2*C+IDX_W-1 -: C];
  assign ent_ty   = mem_rd_data[C+IDX_W-1 -: C];
  assign pick_hx  = pick_ent_r[ENT_W-1 -: C];
  assign pick_hy  = pick_ent_r[ENT_W-1-C -: C];
  assign pick_tx  = pick_ent_r[2*C+IDX_W-1 -: C];
  assign pick_ty  = pick_ent_r[C+IDX_W-1 -: C];
  assign pick_num = pick_ent_r[IDX_W-1:0];

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign has_room  = cnt_r < CNT_W'(MAX_PATHS);
  assign last_scan = (CNT_W'(scan_r) + CNT_W'(1)) == cnt_r;
  assign last_slot = (CNT_W'(slot_r) + CNT_W'(1)) == cnt_r;
  // A tie between the two ends goes to the tail, which reverses the path.
  assign head_closer = dist_head < dist_tail;
  assign take_pick   = first_r || (d_r < best_r);

  gnpo_path_store #(
    .DEPTH  (MAX_PATHS),
    .DATA_W (ENT_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (scan_r),
    .rd_data (mem_rd_data)
  );

  gnpo_dist_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (dist_start),
    .cur_x     (cur_x_r),
    .cur_y     (cur_y_r),
    .head_x    (ent_hx),
    .head_y    (ent_hy),
    .tail_x    (ent_tx),
    .tail_y    (ent_ty),
    .dist_head (dist_head),
    .dist_tail (dist_tail),
    .status    (dist_st)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gnpo_pkg::ST_LOAD: begin
        if (in_fire && in_ch.last_path) begin
          state_nxt = gnpo_pkg::ST_READ;
        end
      end
      gnpo_pkg::ST_READ:  state_nxt = gnpo_pkg::ST_START;
      gnpo_pkg::ST_START: state_nxt = gnpo_pkg::ST_DIST;
      gnpo_pkg::ST_DIST: begin
        if (dist_st.done) begin
          state_nxt = gnpo_pkg::ST_CMP1;
        end
      end
      gnpo_pkg::ST_CMP1: state_nxt = gnpo_pkg::ST_CMP2;
      gnpo_pkg::ST_CMP2: begin
        state_nxt = last_scan ? gnpo_pkg::ST_SWAP1 : gnpo_pkg::ST_READ;
      end
      gnpo_pkg::ST_SWAP1: state_nxt = gnpo_pkg::ST_SWAP2;
      gnpo_pkg::ST_SWAP2: state_nxt = gnpo_pkg::ST_EMIT;
      gnpo_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_nxt = last_slot ? gnpo_pkg::ST_LOAD : gnpo_pkg::ST_READ;
        end
      end
      default: state_nxt = gnpo_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ch.ready  = 1'b0;
    dist_start   = 1'b0;
    mem_rd_en    = 1'b0;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = cnt_r[IDX_W-1:0];
    mem_wr_data  = {in_ch.first_x ^ SIGN_FLIP, in_ch.first_y ^ SIGN_FLIP,
                    in_ch.final_x ^ SIGN_FLIP, in_ch.final_y ^ SIGN_FLIP,
                    cnt_r[IDX_W-1:0]};
    emit_go      = 1'b0;
    case (state_r)
      gnpo_pkg::ST_LOAD: begin
        in_ch.ready = 1'b1;
        mem_wr_en   = in_ch.valid && has_room;
      end
      gnpo_pkg::ST_READ:  mem_rd_en = 1'b1;
      gnpo_pkg::ST_START: dist_start = 1'b1;
      // The swap takes two writes: the winner into the current slot, then
      // the old occupant into the winner's place.
      gnpo_pkg::ST_SWAP1: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = slot_r;
        mem_wr_data = pick_ent_r;
      end
      gnpo_pkg::ST_SWAP2: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pick_r;
        mem_wr_data = slot_ent_r;
      end
      gnpo_pkg::ST_EMIT: emit_go = !out_valid_r || out_ch.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gnpo_pkg::ST_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
      start_x_r   <= SIGN_FLIP;
      start_y_r   <= SIGN_FLIP;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid) begin
        case (gnpo_pkg::cfg_reg_t'(cfg_ch.index))
          gnpo_pkg::REG_START_X: start_x_r <= cfg_ch.data ^ SIGN_FLIP;
          gnpo_pkg::REG_START_Y: start_y_r <= cfg_ch.data ^ SIGN_FLIP;
          default: begin
          end
        endcase
      end

      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == gnpo_pkg::ST_LOAD && in_fire) begin
        if (has_room) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end else begin
          drop_r <= 1'b1;
        end
        if (in_ch.last_path) begin
          first_r <= 1'b1;
        end
      end

      if (state_r == gnpo_pkg::ST_CMP2) begin
        first_r <= 1'b0;
      end

      if (emit_go) begin
        if (last_slot) begin
          cnt_r  <= '0;
          drop_r <= 1'b0;
        end else begin
          first_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      gnpo_pkg::ST_LOAD: begin
        if (in_fire && in_ch.last_path) begin
          slot_r  <= '0;
          scan_r  <= '0;
          cur_x_r <= start_x_r;
          cur_y_r <= start_y_r;
        end
      end
      gnpo_pkg::ST_START: begin
        if (scan_r == slot_r) begin
          slot_ent_r <= mem_rd_data;
        end
      end
      gnpo_pkg::ST_CMP1: begin
        rev_r <= !head_closer;
        d_r   <= head_closer ? dist_head : dist_tail;
      end
      gnpo_pkg::ST_CMP2: begin
        if (take_pick) begin
          best_r     <= d_r;
          pick_r     <= scan_r;
          pick_rev_r <= rev_r;
          pick_ent_r <= mem_rd_data;
        end
        if (!last_scan) begin
          scan_r <= scan_r + IDX_W'(1);
        end
      end
      gnpo_pkg::ST_SWAP1: begin
        // The cursor moves to the far end of the chosen path.
        cur_x_r <= pick_rev_r ? pick_hx : pick_tx;
        cur_y_r <= pick_rev_r ? pick_hy : pick_ty;
      end
      gnpo_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_num_r  <= gnpo_pkg::PATH_NUM_W'(pick_num);
          out_rev_r  <= pick_rev_r;
          out_ovf_r  <= drop_r;
          out_last_r <= last_slot;
          if (!last_slot) begin
            slot_r <= slot_r + IDX_W'(1);
            scan_r <= slot_r + IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.path_number   = out_num_r;
  assign out_ch.reversed      = out_rev_r;
  assign out_ch.overflowed    = out_ovf_r;
  assign out_ch.last_of_order = out_last_r;

  `ASSERT_IMPLIES(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_PATHS), "load count past capacity")
  `ASSERT_IMPLIES(a_scan_range, state_r != gnpo_pkg::ST_LOAD,
                  (CNT_W'(scan_r) < cnt_r) && (slot_r <= scan_r), "scan index out of range")
  `ASSERT_IMPLIES(a_start_idle, dist_start, !dist_st.busy, "distance unit restarted while busy")
  `ASSERT_NEXT(a_emit_valid, emit_go, out_valid_r && (state_r != gnpo_pkg::ST_EMIT),
               "result not presented after emit")

endmodule

`default_nettype wire

FILE: rtl/core/gnpo_path_store.sv
// Single-write, single-read path entry memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gnpo_path_store #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 134
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/gnpo_dist_unit.sv
// Squared distance unit: cursor to both path ends over one shared half-width multiplier.
`timescale 1ns / 1ps
`default_nettype none

module gnpo_dist_unit #(
  parameter int COORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [COORD_BITS-1:0]       cur_x,
  input  logic [COORD_BITS-1:0]       cur_y,
  input  logic [COORD_BITS-1:0]       head_x,
  input  logic [COORD_BITS-1:0]       head_y,
  input  logic [COORD_BITS-1:0]       tail_x,
  input  logic [COORD_BITS-1:0]       tail_y,
  output logic [2*COORD_BITS:0]       dist_head,
  output logic [2*COORD_BITS:0]       dist_tail,
  output gnpo_pkg::dist_status_t      status
);

  localparam int C      = COORD_BITS;
  localparam int H      = (COORD_BITS + 1) / 2;
  localparam int PW     = 2 * H;
  localparam int DIST_W = 2 * COORD_BITS + 1;

  // Each of the four coordinate terms takes four steps: one difference and
  // three partial products (high*high, high*low, low*low).
  logic [3:0]        u_r;
  logic              run_r;
  logic              drain_r;
  logic              done_r;
  logic [C-1:0]      diff_r;
  logic [C-1:0]      diff_nxt;
  logic [PW-1:0]     prod_r;
  logic [PW-1:0]     prod_nxt;
  logic [1:0]        prod_kind_r;
  logic              prod_tail_r;
  logic              prod_vld_r;
  logic [DIST_W-1:0] acc_head_r;
  logic [DIST_W-1:0] acc_tail_r;
  logic [DIST_W-1:0] acc_head_nxt;
  logic [DIST_W-1:0] acc_tail_nxt;
  logic [DIST_W-1:0] term;

  logic [1:0]   sub_step;
  logic [C-1:0] op_a;
  logic [C-1:0] op_b;
  logic [C:0]   a_minus_b;
  logic [C:0]   b_minus_a;
  logic [H-1:0] half_hi;
  logic [H-1:0] half_lo;
  logic [H-1:0] mul_a;
  logic [H-1:0] mul_b;

  assign sub_step = u_r[1:0];

  // Term order: head x, head y, tail x, tail y.
  always_comb begin
    op_a = u_r[2] ? cur_y : cur_x;
    case (u_r[3:2])
      2'd0:    op_b = head_x;
      2'd1:    op_b = head_y;
      2'd2:    op_b = tail_x;
      2'd3:    op_b = tail_y;
      default: op_b = head_x;
    endcase
  end

  assign a_minus_b = {1'b0, op_a} - {1'b0, op_b};
  assign b_minus_a = {1'b0, op_b} - {1'b0, op_a};
  assign diff_nxt  = a_minus_b[C] ? b_minus_a[C-1:0] : a_minus_b[C-1:0];

  assign half_hi = H'(diff_r[C-1:H]);
  assign half_lo = diff_r[H-1:0];
  assign mul_a   = (sub_step == 2'd3) ? half_lo : half_hi;
  assign mul_b   = (sub_step == 2'd1) ? half_hi : half_lo;
  assign prod_nxt = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    case (prod_kind_r)
      2'd1:    term = DIST_W'(prod_r) << PW;
      2'd2:    term = DIST_W'(prod_r) << (H + 1);
      2'd3:    term = DIST_W'(prod_r);
      default: term = '0;
    endcase
  end

  always_comb begin
    acc_head_nxt = acc_head_r;
    acc_tail_nxt = acc_tail_r;
    if (start) begin
      acc_head_nxt = '0;
      acc_tail_nxt = '0;
    end else if (prod_vld_r) begin
      if (prod_tail_r) begin
        acc_tail_nxt = acc_tail_r + term;
      end else begin
        acc_head_nxt = acc_head_r + term;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r        <= '0;
      run_r      <= 1'b0;
      drain_r    <= 1'b0;
      done_r     <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      done_r     <= drain_r;
      drain_r    <= run_r && (u_r == 4'd15);
      prod_vld_r <= run_r && (sub_step != 2'd0);
      if (start) begin
        run_r <= 1'b1;
        u_r   <= '0;
      end else if (run_r) begin
        u_r <= u_r + 4'd1;
        if (u_r == 4'd15) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_r && (sub_step == 2'd0)) begin
      diff_r <= diff_nxt;
    end
    if (run_r && (sub_step != 2'd0)) begin
      prod_r      <= prod_nxt;
      prod_kind_r <= sub_step;
      prod_tail_r <= u_r[3];
    end
    acc_head_r <= acc_head_nxt;
    acc_tail_r <= acc_tail_nxt;
  end

  assign dist_head   = acc_head_r;
  assign dist_tail   = acc_tail_r;
  assign status.busy = run_r | drain_r;
  assign status.done = done_r;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for the greedy nearest-path ordering core: scoreboard class, drivers and phases.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_PATHS  = 64;
  localparam int COORD_BITS = 32;
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = 32'sh7fff_ffff;
  // Indexes with no register behind them; the core must ignore writes to them.
  localparam logic [gnpo_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [gnpo_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int FINISH_CYCLES = 40;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    coord_t final_x;
    coord_t final_y;
    logic   last_path;
  } path_beat_t;

  typedef struct packed {
    logic [gnpo_pkg::PATH_NUM_W-1:0] path_number;
    logic                            reversed;
    logic                            overflowed;
    logic                            last_of_order;
  } order_beat_t;

  class path_order_board;
    path_beat_t  held[MAX_PATHS];
    int          origin[MAX_PATHS];
    int          loaded;
    bit          dropped;
    coord_t      start_x;
    coord_t      start_y;
    order_beat_t due_order[$];
    int          errors;

    function new();
      loaded  = 0;
      dropped = 0;
      start_x = '0;
      start_y = '0;
      errors  = 0;
    endfunction

    function void set_register(logic [gnpo_pkg::CFG_IDX_W-1:0] idx,
                               logic [COORD_BITS-1:0] data);
      case (idx)
        gnpo_pkg::REG_START_X: start_x = data;
        gnpo_pkg::REG_START_Y: start_y = data;
        default: ;
      endcase
    endfunction

    function logic [COORD_BITS-1:0] axis_gap(coord_t a, coord_t b);
      logic [COORD_BITS:0] d;
      logic [COORD_BITS:0] m;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      m = d[COORD_BITS] ? (~d + 1'b1) : d;
      return m[COORD_BITS-1:0];
    endfunction

    // Exact squared distance; two 64-bit squares need 65 bits to sum.
    function logic [65:0] span_sq(coord_t ax, coord_t ay, coord_t bx, coord_t by);
      logic [65:0] dx;
      logic [65:0] dy;
      dx = 66'(axis_gap(ax, bx));
      dy = 66'(axis_gap(ay, by));
      return dx * dx + dy * dy;
    endfunction

    function void note_path(path_beat_t p);
      int          slot;
      int          scan;
      int          pick;
      int          tmp_origin;
      bit          rev;
      bit          pick_rev;
      bit          have;
      logic [65:0] df;
      logic [65:0] dl;
      logic [65:0] d;
      logic [65:0] best;
      coord_t      cx;
      coord_t      cy;
      path_beat_t  tmp;
      order_beat_t r;
      if (loaded < MAX_PATHS) begin
        held[loaded]   = p;
        origin[loaded] = loaded;
        loaded++;
      end else begin
        dropped = 1'b1;
      end
      if (!p.last_path) return;
      cx = start_x;
      cy = start_y;
      for (slot = 0; slot < loaded; slot++) begin
        have     = 1'b0;
        pick     = slot;
        pick_rev = 1'b0;
        best     = '0;
        for (scan = slot; scan < loaded; scan++) begin
          df  = span_sq(cx, cy, held[scan].first_x, held[scan].first_y);
          dl  = span_sq(cx, cy, held[scan].final_x, held[scan].final_y);
          // An equal distance picks the last point, so the path runs backward.
          rev = (df >= dl);
          d   = rev ? dl : df;
          if (!have || d < best) begin
            have     = 1'b1;
            best     = d;
            pick     = scan;
            pick_rev = rev;
          end
        end
        if (pick != slot) begin
          tmp          = held[slot];
          held[slot]   = held[pick];
          held[pick]   = tmp;
          tmp_origin   = origin[slot];
          origin[slot] = origin[pick];
          origin[pick] = tmp_origin;
        end
        if (pick_rev) begin
          cx = held[slot].first_x;
          cy = held[slot].first_y;
        end else begin
          cx = held[slot].final_x;
          cy = held[slot].final_y;
        end
        r.path_number   = origin[slot][gnpo_pkg::PATH_NUM_W-1:0];
        r.reversed      = pick_rev;
        r.overflowed    = dropped;
        r.last_of_order = (slot == loaded - 1);
        due_order       = {due_order, r};
      end
      loaded  = 0;
      dropped = 1'b0;
    endfunction

    function void check_result(order_beat_t got);
      order_beat_t want;
      if (due_order.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat path_number %0d reversed %0b", $time,
                 got.path_number, got.reversed);
        return;
      end
      want = due_order.pop_front();
      if (got.path_number !== want.path_number || got.reversed !== want.reversed ||
          got.overflowed !== want.overflowed || got.last_of_order !== want.last_of_order) begin
        errors++;
        $display("%0t: path_number exp %0d got %0d, reversed exp %0b got %0b", $time,
                 want.path_number, got.path_number, want.reversed, got.reversed);
        $display("%0t: overflowed exp %0b got %0b, last_of_order exp %0b got %0b", $time,
                 want.overflowed, got.overflowed, want.last_of_order, got.last_of_order);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   sink_idle_pct;

  path_order_board board = new();

  gnpo_path_if #(.COORD_BITS(COORD_BITS)) in_ch ();
  gnpo_result_if                          out_ch ();
  gnpo_cfg_if #(.DATA_W(COORD_BITS))      cfg_ch ();

  greedy_nearest_path_order_core #(
    .MAX_PATHS (MAX_PATHS),
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    order_beat_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{path_number: out_ch.path_number, reversed: out_ch.reversed,
              overflowed: out_ch.overflowed, last_of_order: out_ch.last_of_order};
      board.check_result(got);
    end
  end

  function automatic path_beat_t make_path(coord_t fx, coord_t fy, coord_t lx, coord_t ly,
                                           logic last);
    path_beat_t p;
    p = '{first_x: fx, first_y: fy, final_x: lx, final_y: ly, last_path: last};
    return p;
  endfunction

  // Extremes, full-range values and a tight cluster around zero so that ties occur.
  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(40)) - 20;
    endcase
  endfunction

  function automatic path_beat_t rand_path(logic last);
    path_beat_t p;
    p = make_path(rand_coord(), rand_coord(), rand_coord(), rand_coord(), last);
    if ($urandom_range(9) == 0) begin
      p.final_x = p.first_x;
      p.final_y = p.first_y;
    end
    return p;
  endfunction

  task automatic send_path(input path_beat_t p);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.first_x   <= p.first_x;
    in_ch.first_y   <= p.first_y;
    in_ch.final_x   <= p.final_x;
    in_ch.final_y   <= p.final_y;
    in_ch.last_path <= p.last_path;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_path(p);
  endtask

  task automatic send_random_set(input int count);
    for (int i = 0; i < count; i++) send_path(rand_path(i == count - 1));
  endtask

  // Fills the store, then sends paths that must be dropped; the last one is dropped too.
  task automatic send_overflow_set();
    int total;
    total = MAX_PATHS + $urandom_range(1, 3);
    for (int i = 0; i < total; i++) send_path(rand_path(i == total - 1));
  endtask

  task automatic run_random(input int budget, input bit with_overflow);
    int sent;
    int count;
    sent = 0;
    while (sent < budget) begin
      count = $urandom_range(1, 8);
      send_random_set(count);
      sent += count;
      if (with_overflow && sent >= budget / 2) begin
        send_overflow_set();
        with_overflow = 1'b0;
      end
    end
  endtask

  // Lowers valid and waits until every expected result beat has been taken.
  task automatic wait_order_done();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.due_order.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gnpo_pkg::CFG_IDX_W-1:0] idx,
                           input logic [COORD_BITS-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.set_register(idx, data);
  endtask

  task automatic program_start(input coord_t x, input coord_t y, input bit spare);
    write_reg(gnpo_pkg::REG_START_X, x);
    if (spare) write_reg(REG_SPARE_A, $urandom);
    write_reg(gnpo_pkg::REG_START_Y, y);
    if (spare) write_reg(REG_SPARE_B, $urandom);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    src_idle_pct    = 16;
    sink_idle_pct   = 57;
    in_ch.valid     = 1'b0;
    in_ch.first_x   = '0;
    in_ch.first_y   = '0;
    in_ch.final_x   = '0;
    in_ch.final_y   = '0;
    in_ch.last_path = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed sets with the start point left at its reset value.
    // A single degenerate path: both ends tie, so it is cut backward.
    send_path(make_path(0, 0, 0, 0, 1'b1));
    // Corner coordinates, a tie between two paths, and a path centered on the cursor.
    send_path(make_path(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0));
    send_path(make_path(10, 0, 20, 0, 1'b0));
    send_path(make_path(0, 10, 0, 20, 1'b0));
    send_path(make_path(-30, 0, 30, 0, 1'b0));
    send_path(make_path(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1));
    // Identical paths: array order and the swap decide the sequence.
    send_path(make_path(7, -7, -7, 7, 1'b0));
    send_path(make_path(7, -7, -7, 7, 1'b0));
    send_path(make_path(7, -7, -7, 7, 1'b0));
    send_path(make_path(7, -7, -7, 7, 1'b1));
    // Alternating bit patterns and all ones.
    send_path(make_path(32'sh5555_5555, 32'shaaaa_aaaa, -1, -1, 1'b0));
    send_path(make_path(32'shaaaa_aaaa, 32'sh5555_5555, 1, -1, 1'b0));
    send_path(make_path(-1, 1, COORD_MAX, COORD_MIN, 1'b1));
    wait_order_done();

    program_start(COORD_MIN, COORD_MAX, 1'b0);
    src_idle_pct  = 16;
    sink_idle_pct = 57;
    send_path(make_path(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 1'b1));
    run_random(8, 1'b0);
    wait_order_done();

    program_start(COORD_MAX, COORD_MIN, 1'b1);
    src_idle_pct  = 57;
    sink_idle_pct = 16;
    run_random(8, 1'b1);
    wait_order_done();

    program_start($urandom, $urandom, 1'b0);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(10, 1'b0);
    wait_order_done();

    repeat (FINISH_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.due_order.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
